@@ rtl/htpl_pkg.sv @@
`default_nettype none

package htpl_pkg;

    localparam int MOD_W     = 11;
    localparam int IDX_IN_W  = 10;
    localparam int KEY_W     = 32;
    localparam int VAL_W     = 32;
    localparam int MOD_RESET = 1024;

    // remainder unit: dividend width, bits retired per cycle, cycles per division
    localparam int DIV_W     = 32;
    localparam int DIV_BPC   = 2;
    localparam int DIV_CYC   = DIV_W / DIV_BPC;
    localparam int DIV_CNT_W = $clog2(DIV_CYC);

    localparam logic CMD_WRITE  = 1'b0;
    localparam logic CMD_LOOKUP = 1'b1;

    typedef struct packed {
        logic                command;
        logic [IDX_IN_W-1:0] entry_index;
        logic [KEY_W-1:0]    entry_key;
        logic [VAL_W-1:0]    entry_value;
        logic [KEY_W-1:0]    search_hash;
    } t_in_item;

    typedef struct packed {
        logic             found;
        logic [VAL_W-1:0] found_value;
    } t_out_item;

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_DIV   = 4'b0100,
        S_CHECK = 4'b1000
    } t_state;

    typedef struct packed {
        logic clr_step;
        logic wr_entry;
        logic lookup_load;
        logic probe_next;
        logic res_load;
        logic res_hit;
    } t_dp_cmd;

    typedef struct packed {
        logic clr_last;
        logic div_done;
        logic key_empty;
        logic key_match;
        logic probe_last;
    } t_dp_stat;

endpackage

`default_nettype wire

@@ rtl/htpl_div.sv @@
`default_nettype none

module htpl_div (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       i_start,
    input  wire [htpl_pkg::DIV_W-1:0] i_dividend,
    input  wire [htpl_pkg::MOD_W-1:0] i_divisor,
    output logic                      o_done,
    output logic [htpl_pkg::MOD_W-1:0] o_rem
);
    import htpl_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DIV_W-1:0]     r_quo;
    logic [MOD_W-1:0]     r_rem;

    logic [DIV_W-1:0]     n_quo;
    logic [MOD_W-1:0]     n_rem;
    logic [MOD_W:0]       trial;

    // restoring remainder, DIV_BPC dividend bits per cycle; rem < divisor keeps
    // each trial below twice the divisor, so one subtract per bit
    always_comb begin
        n_rem = r_rem;
        n_quo = r_quo;
        trial = '0;
        for (int i = 0; i < DIV_BPC; i++) begin
            trial = {n_rem, n_quo[DIV_W-1]};
            if (trial >= {1'b0, i_divisor}) begin
                trial = trial - {1'b0, i_divisor};
            end
            n_rem = trial[MOD_W-1:0];
            n_quo = {n_quo[DIV_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == DIV_CNT_W'(DIV_CYC - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
        end else if (r_busy) begin
            r_quo <= n_quo;
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

`default_nettype wire

@@ rtl/htpl_dp.sv @@
`default_nettype none

module htpl_dp #(
    parameter int TABLE_DEPTH = 1024
) (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_cfg_we,
    input  wire [htpl_pkg::MOD_W-1:0]  i_cfg_wdata,
    input  htpl_pkg::t_in_item         i_item,
    input  htpl_pkg::t_dp_cmd          i_cmd,
    output htpl_pkg::t_dp_stat         o_stat,
    output htpl_pkg::t_out_item        o_result,
    output logic                       o_match_zero
);
    import htpl_pkg::*;

    localparam int IW     = $clog2(TABLE_DEPTH);
    localparam int ENT_W  = KEY_W + VAL_W;
    localparam int M_CAP  = (TABLE_DEPTH < 2047) ? TABLE_DEPTH : 2047;

    logic [ENT_W-1:0] mem [TABLE_DEPTH];

    logic [MOD_W-1:0] r_modulus;
    logic [IW-1:0]    r_clr_addr;
    logic [KEY_W-1:0] r_hash;
    logic [DIV_W-1:0] r_step;
    logic [MOD_W-1:0] r_probes;
    logic [ENT_W-1:0] r_rd;
    t_out_item        r_result;

    logic [MOD_W-1:0] m_eff;
    logic [DIV_W-1:0] step_nx;
    logic [DIV_W-1:0] dividend;
    logic             div_start;
    logic             div_done;
    logic [MOD_W-1:0] div_rem;
    logic [IW-1:0]    rd_addr;
    logic [KEY_W-1:0] rd_key;
    logic [VAL_W-1:0] rd_val;
    logic             wr_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus <= MOD_W'(MOD_RESET);
        end else if (i_cfg_we) begin
            r_modulus <= i_cfg_wdata;
        end
    end

    always_comb begin
        if (r_modulus == '0) begin
            m_eff = MOD_W'(1);
        end else if (32'(r_modulus) > M_CAP) begin
            m_eff = MOD_W'(M_CAP);
        end else begin
            m_eff = r_modulus;
        end
    end

    // step stays at or below 2^31 after the first halving, so step + slot fits
    assign step_nx   = (r_step >> 1) + DIV_W'(1);
    assign div_start = i_cmd.lookup_load | i_cmd.probe_next;
    assign dividend  = i_cmd.lookup_load ? i_item.search_hash
                                         : step_nx + DIV_W'(div_rem);

    htpl_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (dividend),
        .i_divisor  (m_eff),
        .o_done     (div_done),
        .o_rem      (div_rem)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clr_step) begin
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.lookup_load) begin
            r_hash   <= i_item.search_hash;
            r_step   <= i_item.search_hash;
            r_probes <= '0;
        end else if (i_cmd.probe_next) begin
            r_step   <= step_nx;
            r_probes <= r_probes + 1'b1;
        end
    end

    assign wr_ok   = (32'(i_item.entry_index) < TABLE_DEPTH);
    assign rd_addr = IW'(div_rem);

    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_step) begin
            mem[r_clr_addr] <= '0;
        end else if (i_cmd.wr_entry && wr_ok) begin
            mem[IW'(i_item.entry_index)] <= {i_item.entry_key, i_item.entry_value};
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd <= mem[rd_addr];
    end

    assign rd_key = r_rd[ENT_W-1:VAL_W];
    assign rd_val = r_rd[VAL_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.res_load) begin
            r_result.found       <= i_cmd.res_hit;
            r_result.found_value <= i_cmd.res_hit ? rd_val : '0;
        end
    end

    always_comb begin
        o_stat.clr_last   = (r_clr_addr == IW'(TABLE_DEPTH - 1));
        o_stat.div_done   = div_done;
        o_stat.key_empty  = (rd_key[KEY_W-1:1] == '0);
        o_stat.key_match  = (rd_key == r_hash) && (rd_val != '0);
        o_stat.probe_last = (r_probes == (m_eff - 1'b1));
    end

    // key matches but the slot holds no value: ends the probe as a miss
    assign o_match_zero = (rd_key == r_hash) && (rd_val == '0);

    assign o_result = r_result;

endmodule

`default_nettype wire

@@ rtl/htpl_ctrl.sv @@
`default_nettype none

module htpl_ctrl (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 start,
    input  wire                 i_command,
    input  htpl_pkg::t_dp_stat  i_stat,
    input  wire                 i_key_hit,
    output htpl_pkg::t_dp_cmd   o_cmd,
    output logic                busy,
    output logic                o_strobe
);
    import htpl_pkg::*;

    t_state  r_state;
    t_state  n_state;
    logic    r_strobe;
    t_dp_cmd cmd;

    always_comb begin
        n_state = r_state;
        cmd     = '0;
        unique case (r_state)
            S_CLEAR: begin
                cmd.clr_step = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    if (i_command == CMD_LOOKUP) begin
                        cmd.lookup_load = 1'b1;
                        n_state         = S_DIV;
                    end else begin
                        cmd.wr_entry = 1'b1;
                    end
                end
            end
            S_DIV: begin
                if (i_stat.div_done) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                // empty wins over match: hash 0 or 1 never hits
                priority if (i_stat.key_empty) begin
                    cmd.res_load = 1'b1;
                    n_state      = S_IDLE;
                end else if (i_key_hit) begin
                    cmd.res_load = 1'b1;
                    cmd.res_hit  = i_stat.key_match;
                    n_state      = S_IDLE;
                end else if (i_stat.probe_last) begin
                    cmd.res_load = 1'b1;
                    n_state      = S_IDLE;
                end else begin
                    cmd.probe_next = 1'b1;
                    n_state        = S_DIV;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= cmd.res_load;
        end
    end

    assign o_cmd    = cmd;
    assign busy     = (r_state != S_IDLE);
    assign o_strobe = r_strobe;

endmodule

`default_nettype wire

@@ rtl/hash_table_probe_lookup.sv @@
`default_nettype none

// Open-addressed hash table with a halving probe step.
// Command channel: an item is taken at a rising edge with start high and busy
// low. A write command (command = 0) loads one slot in that cycle and gives no
// result; another item may follow in the next cycle. A lookup (command = 1)
// starts at slot hash mod M and probes with step = (step >> 1) + 1.
// Result channel: o_strobe is high for one cycle with o_result; the receiver
// cannot stall, so every result is taken on the edge that ends that cycle.
// Each slot read runs the 2-bit-per-cycle remainder unit (32-bit dividend mod M)
// and then checks the registered memory read. A lookup that reads k slots raises
// o_strobe from a register set by its last check, and a new item can be taken in
// the strobe cycle; k runs from 1 up to M.
// The configuration register (M) is loaded by i_cfg_we / i_cfg_wdata; the user is
// to write it only while the block is idle, which the block itself does not
// enforce. It resets to 1024 and acts as 1 when 0 and as TABLE_DEPTH when larger.
// Reset: the table is cleared by a sweep over all TABLE_DEPTH slots, one slot per
// cycle, with busy high; configuration writes are taken during the sweep.
module hash_table_probe_lookup #(
    parameter int TABLE_DEPTH = 1024
) (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        start,
    output logic                       busy,
    input  htpl_pkg::t_in_item         i_item,
    output logic                       o_strobe,
    output htpl_pkg::t_out_item        o_result,
    input  wire                        i_cfg_we,
    input  wire [htpl_pkg::MOD_W-1:0]  i_cfg_wdata
);
    import htpl_pkg::*;

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;
    logic     dp_match_zero;

    htpl_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .start     (start),
        .i_command (i_item.command),
        .i_stat    (dp_stat),
        .i_key_hit (dp_stat.key_match | dp_match_zero),
        .o_cmd     (dp_cmd),
        .busy      (busy),
        .o_strobe  (o_strobe)
    );

    htpl_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_item       (i_item),
        .i_cmd        (dp_cmd),
        .o_stat       (dp_stat),
        .o_result     (o_result),
        .o_match_zero (dp_match_zero)
    );

endmodule

`default_nettype wire

@@ verif/hash_table_probe_lookup_tb.sv @@
`timescale 1ns / 100ps

module hash_table_probe_lookup_tb;
    import htpl_pkg::*;

    localparam int DEPTH       = 1024;
    // worst lookup reads every slot, each through a full division; taken several times over
    localparam int STALL_LIMIT = 80000;

    logic                 i_clk;
    logic                 i_rst_n     = 1'b0;
    logic                 start       = 1'b0;
    logic                 busy;
    t_in_item             i_item      = '0;
    logic                 o_strobe;
    t_out_item            o_result;
    logic                 i_cfg_we    = 1'b0;
    logic [MOD_W-1:0]     i_cfg_wdata = '0;

    // predictor state: table contents and modulus register
    logic [KEY_W-1:0]     key_tbl [DEPTH] = '{default: '0};
    logic [VAL_W-1:0]     val_tbl [DEPTH] = '{default: '0};
    logic [MOD_W-1:0]     mod_cfg = MOD_W'(MOD_RESET);

    t_in_item             feed_q [$];
    t_out_item            answer_q [$];
    logic [KEY_W-1:0]     live_keys [$];
    int unsigned          queued_cnt   = 0;
    int unsigned          taken_cnt    = 0;
    int unsigned          mismatch_cnt = 0;
    int unsigned          stall_cnt    = 0;
    int unsigned          gap_pct      = 10;
    logic                 item_taken   = 1'b0;

    hash_table_probe_lookup uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_item      (i_item),
        .o_strobe    (o_strobe),
        .o_result    (o_result),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    function automatic int unsigned eff_modulus(logic [MOD_W-1:0] cfg);
        if (cfg == 0) return 1;
        if (cfg > DEPTH) return DEPTH;
        return 32'(cfg);
    endfunction

    // slot visited by the n-th probe of a hash (n = 0 is the home slot)
    function automatic int unsigned probe_slot(logic [31:0] hash, int unsigned m,
                                               int unsigned n);
        logic [31:0] step;
        int unsigned slot;
        step = hash;
        slot = hash % m;
        repeat (n) begin
            step = (step >> 1) + 1;
            slot = (step + slot) % m;
        end
        return slot;
    endfunction

    function automatic t_out_item probe_lookup(logic [KEY_W-1:0] hash);
        int unsigned m;
        int unsigned slot;
        logic [31:0] step;
        t_out_item   res;
        m    = eff_modulus(mod_cfg);
        step = hash;
        slot = hash % m;
        res  = '0;
        for (int unsigned n = 0; n < m; n++) begin
            if (key_tbl[slot] <= 1) break;
            if (key_tbl[slot] == hash) begin
                res.found       = (val_tbl[slot] != 0);
                res.found_value = res.found ? val_tbl[slot] : '0;
                break;
            end
            step = (step >> 1) + 1;
            slot = (step + slot) % m;
        end
        return res;
    endfunction

    task automatic log_mismatch(input string msg);
        $display("ERROR @%0t: %s", $time, msg);
        mismatch_cnt++;
    endtask

    // unused fields carry random junk; the block must ignore them
    task automatic put_write(input logic [IDX_IN_W-1:0] idx, input logic [KEY_W-1:0] key,
                             input logic [VAL_W-1:0] val);
        t_in_item it;
        it.command     = CMD_WRITE;
        it.entry_index = idx;
        it.entry_key   = key;
        it.entry_value = val;
        it.search_hash = $urandom;
        feed_q.push_back(it);
        queued_cnt++;
    endtask

    task automatic put_lookup(input logic [KEY_W-1:0] hash);
        t_in_item it;
        it.command     = CMD_LOOKUP;
        it.entry_index = IDX_IN_W'($urandom);
        it.entry_key   = $urandom;
        it.entry_value = $urandom;
        it.search_hash = hash;
        feed_q.push_back(it);
        queued_cnt++;
    endtask

    task automatic set_modulus(input logic [MOD_W-1:0] cfg);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= cfg;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        mod_cfg      = cfg;
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        while (taken_cnt != queued_cnt || answer_q.size() != 0 || busy)
            @(negedge i_clk);
        // a write finishes in its own cycle; a few spare cycles cover it
        repeat (4) @(negedge i_clk);
    endtask

    // mostly keys placed along their own probe chains, so lookups hit after
    // a few probes; the rest is empty markers, zero values and stray hashes
    task automatic queue_phase(input logic [MOD_W-1:0] cfg, input int n_items);
        int unsigned m;
        int unsigned roll;
        logic [KEY_W-1:0]    key;
        logic [IDX_IN_W-1:0] idx;
        m = eff_modulus(cfg);
        for (int i = 0; i < n_items; i++) begin
            roll = $urandom_range(99);
            if (roll < 35) begin
                roll = $urandom_range(99);
                key  = (roll < 5) ? $urandom_range(1, 0) : $urandom;
                if (roll < 5 || roll >= 90)
                    idx = IDX_IN_W'($urandom_range(DEPTH - 1));
                else
                    idx = IDX_IN_W'(probe_slot(key, m, $urandom_range(3)));
                put_write(idx, key, ($urandom_range(99) < 8) ? 32'd0 : $urandom);
                if (key > 1) begin
                    live_keys.push_back(key);
                    if (live_keys.size() > 48) void'(live_keys.pop_front());
                end
            end else if (roll < 80 && live_keys.size() != 0) begin
                put_lookup(live_keys[$urandom_range(live_keys.size() - 1)]);
            end else if (roll < 88) begin
                put_lookup($urandom_range(1, 0));
            end else begin
                put_lookup($urandom);
            end
        end
    endtask

    // driver: hold the beat until taken, then maybe drop start before the next beat
    always @(negedge i_clk) begin
        if (!start || item_taken) begin
            if (feed_q.size() != 0 && $urandom_range(99) >= gap_pct) begin
                i_item <= feed_q.pop_front();
                start  <= 1'b1;
            end else begin
                start  <= 1'b0;
            end
        end
    end

    // monitor: results first, then the beat taken at this edge
    always @(posedge i_clk) begin
        t_out_item want;
        item_taken = i_rst_n && start && !busy;
        if (i_rst_n && o_strobe) begin
            if (answer_q.size() == 0) begin
                log_mismatch("result beat with no lookup pending");
            end else begin
                want = answer_q.pop_front();
                if (o_result.found !== want.found)
                    log_mismatch($sformatf("found %b, expected %b",
                                           o_result.found, want.found));
                if (o_result.found_value !== want.found_value)
                    log_mismatch($sformatf("found_value %h, expected %h",
                                           o_result.found_value, want.found_value));
            end
        end
        if (item_taken) begin
            if (i_item.command == CMD_WRITE) begin
                key_tbl[i_item.entry_index] = i_item.entry_key;
                val_tbl[i_item.entry_index] = i_item.entry_value;
            end else begin
                answer_q.push_back(probe_lookup(i_item.search_hash));
            end
            taken_cnt++;
        end
        if (item_taken || (i_rst_n && o_strobe))
            stall_cnt = 0;
        else
            stall_cnt++;
        if (stall_cnt >= STALL_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        logic [MOD_W-1:0] phase_cfg [10];
        phase_cfg = '{11'd2, 11'd3, 11'd16, 11'd64, 11'd1024,
                      11'd37, 11'd1, 11'd2047, 11'd0, 11'd700};

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed, reset modulus: empty table, hash 0/1, extremes, chains
        put_lookup(32'h0000_0000);
        put_lookup(32'h0000_0001);
        put_lookup(32'hFFFF_FFFF);
        put_write(10'h3FF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        put_lookup(32'hFFFF_FFFF);
        put_write(10'd5, 32'h0000_0405, 32'h0);          // match with zero value
        put_lookup(32'h0000_0405);
        put_write(10'd7, 32'h0000_0001, 32'hDEAD_BEEF);  // key 1 reads as empty
        put_lookup(32'h0000_0C07);
        put_write(10'd10, 32'h0000_080A, 32'h5555_AAAA); // collides with 0x40A
        put_write(10'd528, 32'h0000_040A, 32'hAAAA_5555); // second probe of 0x40A
        put_lookup(32'h0000_040A);
        put_lookup(32'h0000_080A);
        put_write(10'd0, 32'h0000_0000, 32'h1234_5678);
        put_lookup(32'h0000_0400);
        wait_idle();

        set_modulus(11'd1);
        put_write(10'd0, 32'hCAFE_0001, 32'h0000_0001);
        put_lookup(32'hCAFE_0001);
        put_lookup(32'h7FFF_FFFF);                      // probe cap at one slot
        wait_idle();

        set_modulus(11'd0);                              // acts as one slot
        put_lookup(32'hCAFE_0001);
        put_lookup(32'h0000_0012);
        wait_idle();

        set_modulus(11'h7FF);                            // clamps to full depth
        put_lookup(32'hFFFF_FFFF);
        put_lookup(32'h0000_040A);
        wait_idle();

        set_modulus(11'd4);                              // full table, miss hits cap
        put_write(10'd1, 32'h0000_0011, 32'h0000_0111);
        put_write(10'd2, 32'h0000_0022, 32'h0000_0222);
        put_write(10'd3, 32'h0000_0033, 32'h0000_0333);
        put_lookup(32'h0000_0044);
        put_lookup(32'h0000_0033);
        wait_idle();

        foreach (phase_cfg[p]) begin
            gap_pct = (p < 4) ? 10 : (p < 7) ? 79 : 0;
            set_modulus(phase_cfg[p]);
            queue_phase(phase_cfg[p], 110);
            wait_idle();
        end

        repeat (20) @(negedge i_clk);
        if (mismatch_cnt == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
